>>> rtl/sbda_pkg.sv
`timescale 1ns / 1ps

package sbda_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 6;

  // Ten BCD digits cover the full 32-bit magnitude range
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  // Bit counter for the serial conversion (holds VALUE_W itself)
  localparam int BIT_CNT_W = $clog2(VALUE_W + 1);
  // Digit counter for the emitter (holds NUM_DIGITS itself)
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Request from the sequencer to the character emitter
  typedef struct packed {
    logic load;
    logic negative;
  } emit_req_t;

endpackage

>>> rtl/sbda_dabble.sv
`timescale 1ns / 1ps

// Bit-serial binary to BCD conversion (shift and add-3), one input bit per cycle.
module sbda_dabble
  import sbda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [VALUE_W-1:0] mag,
  output logic               conv_busy,
  output logic [BCD_W-1:0]   bcd
);

  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;

  // Add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // Next-value logic: load, shift, or hold
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = BIT_CNT_W'(VALUE_W);
    end else if (cnt_r != '0) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Counter is control state; shift registers need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign conv_busy = (cnt_r != '0);
  assign bcd       = bcd_r;

  // Bit counter never exceeds the word width
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BIT_CNT_W'(VALUE_W))
    else $error("bit counter out of range");

  // A load always restarts a full conversion
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == BIT_CNT_W'(VALUE_W))
    else $error("load did not start a conversion");

  // Counter steps down by one while converting
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !load && cnt_r != '0 |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("bit counter skipped");

endmodule

>>> rtl/sbda_emit.sv
`timescale 1ns / 1ps

// Shifts BCD digits out one per cycle, most significant first, skipping
// leading zeros; a minus sign goes out first for negative values.
module sbda_emit
  import sbda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  emit_req_t         req,
  input  logic [BCD_W-1:0]  bcd,
  output logic              emit_busy,
  output logic              out_strobe,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char
);

  logic [BCD_W-1:0]     dig_r, dig_nxt;
  logic [DIG_CNT_W-1:0] rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic                 lead_r, lead_nxt;
  logic                 valid_r, valid_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic [3:0]           top_dig;

  assign top_dig = dig_r[BCD_W-1 -: 4];

  // Per-cycle character selection
  always_comb begin
    dig_nxt   = dig_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    lead_nxt  = lead_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = 1'b0;
    if (req.load) begin
      dig_nxt  = bcd;
      rem_nxt  = DIG_CNT_W'(NUM_DIGITS);
      neg_nxt  = req.negative;
      lead_nxt = 1'b1;
    end else if (neg_r) begin
      // sign first
      neg_nxt   = 1'b0;
      valid_nxt = 1'b1;
      char_nxt  = ASCII_MINUS;
    end else if (rem_r != '0) begin
      dig_nxt = {dig_r[BCD_W-5:0], 4'd0};
      rem_nxt = rem_r - 1'b1;
      // leading zero is dropped, except for the ones digit
      if (!(lead_r && top_dig == 4'd0 && rem_r != DIG_CNT_W'(1))) begin
        lead_nxt  = 1'b0;
        valid_nxt = 1'b1;
        char_nxt  = ASCII_ZERO | {2'b00, top_dig};
        last_nxt  = (rem_r == DIG_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      neg_r   <= 1'b0;
      lead_r  <= 1'b0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      neg_r   <= neg_nxt;
      lead_r  <= lead_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
  end

  assign emit_busy     = neg_r | (rem_r != '0);
  assign out_strobe    = valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  // Last mark only rides on a strobed character
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r)
    else $error("last mark without strobe");

  // Final character ends the digit sweep
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> !emit_busy)
    else $error("emitter still busy after last character");

  // Minus sign is never the last character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && char_r == ASCII_MINUS |-> !last_r)
    else $error("minus sign marked last");

endmodule

>>> rtl/signed_binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Flow: a request loads the bit-serial shifter; once it finishes, the emitter is loaded
// and sends a minus sign first for negative values, then sweeps 10 digit positions.
// busy stays high until the emitter is done (longer with a minus sign); leading zero
// positions are swept but not strobed, and one request at a time is taken, only while busy is low.
// Characters are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-low reset returns the block to idle, no output strobed.
module signed_binary_to_decimal_ascii_core
  import sbda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_strobe,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last_char
);

  state_t             state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic               accept;
  logic [VALUE_W-1:0] mag;
  logic               conv_busy;
  logic               emit_busy;
  logic [BCD_W-1:0]   bcd;
  emit_req_t          emit_req;

  assign accept = start && (state_r == ST_IDLE);

  // Magnitude; the most negative value wraps to 2^31 unsigned
  assign mag = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(unsigned'(in_value)))
                                   : VALUE_W'(unsigned'(in_value));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (!conv_busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy              = 1'b1;
    emit_req.load     = 1'b0;
    emit_req.negative = neg_r;
    unique case (state_r)
      ST_IDLE: busy          = 1'b0;
      ST_CONV: emit_req.load = !conv_busy;
      ST_EMIT: busy          = 1'b1;
      default: busy          = 1'b1;
    endcase
  end

  assign neg_nxt = accept ? in_value[VALUE_W-1] : neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
  end

  sbda_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .mag       (mag),
    .conv_busy (conv_busy),
    .bcd       (bcd)
  );

  sbda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (emit_req),
    .bcd           (bcd),
    .emit_busy     (emit_busy),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // Accepted request starts the conversion phase
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_CONV)
    else $error("request accepted but conversion not started");

  // Characters appear only during the emit phase
  a_strobe_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == ST_EMIT)
    else $error("character strobed outside emit phase");

  // After the last character the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_char |=> !out_strobe && state_r == ST_IDLE)
    else $error("activity after last character");

endmodule
